// ===== sv/qmbl_pkg.sv =====
// shared constants, types and request/response structs for the quadtree map lookup
package qmbl_pkg;

    // default table sizes
    localparam int NODES_DEF  = 4096;
    localparam int LAYERS_DEF = 16;

    // field widths
    localparam int CMD_W    = 2;
    localparam int NIDX_W   = 12;
    localparam int LNUM_W   = 4;
    localparam int LS_W     = 12;
    localparam int CHILD_W  = 10;
    localparam int MAG_W    = 32;
    localparam int POS_W    = 32;
    localparam int BOX_W    = 31;

    // node address sum: layer start + 4 * child block + quadrant
    localparam int SUM_W = 13;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NODE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LAYER = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [BOX_W-1:0] BOX_RESET = 31'd131072;
    localparam logic [MAG_W-1:0] MAG_SAT   = 32'hFFFF_FFFF;

    // shared divider geometry
    localparam int DIV_NUM_W  = 99;
    localparam int DIV_Q_W    = 64;
    localparam int DIV_STEP_W = 7;

    // square root geometry
    localparam int SQ_RAD_W  = 64;
    localparam int SQ_ROOT_W = 32;
    localparam int SQ_CNT_W  = 6;

    typedef struct packed {
        logic                  start;
        logic [DIV_NUM_W-1:0]  num;
        logic [DIV_Q_W-1:0]    den;
        logic [DIV_STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic                start;
        logic [SQ_RAD_W-1:0] rad;
    } sqrt_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [SQ_ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

// ===== sv/qmbl_if.sv =====
// command and result channel interfaces
interface qmbl_cmd_if;
    import qmbl_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [NIDX_W-1:0]   node_index;
    logic [LNUM_W-1:0]   layer_number;
    logic [LS_W-1:0]     layer_start;
    logic                is_refined;
    logic [CHILD_W-1:0]  child_block;
    logic [MAG_W-1:0]    corner_a;
    logic [MAG_W-1:0]    corner_b;
    logic [MAG_W-1:0]    corner_c;
    logic [MAG_W-1:0]    corner_d;
    logic signed [POS_W-1:0] x_pos;
    logic signed [POS_W-1:0] y_pos;

    modport source (
        output valid, command, node_index, layer_number, layer_start, is_refined,
               child_block, corner_a, corner_b, corner_c, corner_d, x_pos, y_pos,
        input  ready
    );
    modport sink (
        input  valid, command, node_index, layer_number, layer_start, is_refined,
               child_block, corner_a, corner_b, corner_c, corner_d, x_pos, y_pos,
        output ready
    );
endinterface

interface qmbl_res_if;
    import qmbl_pkg::*;
    logic             valid;
    logic             ready;
    logic [MAG_W-1:0] magnification;
    logic             outside_box;
    logic             depth_limited;

    modport source (
        output valid, magnification, outside_box, depth_limited,
        input  ready
    );
    modport sink (
        input  valid, magnification, outside_box, depth_limited,
        output ready
    );
endinterface

// ===== sv/qmbl_ram.sv =====
// generic single-write, single-read ram with registered read data
module qmbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/qmbl_div.sv =====
// restoring divider, one quotient bit per cycle, left-aligned numerator
module qmbl_div (
    input  logic               clk,
    input  logic               rst_n,
    input  qmbl_pkg::div_req_t req,
    output qmbl_pkg::div_rsp_t rsp
);
    import qmbl_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] cnt_reg;
    logic [DIV_NUM_W-1:0]  num_reg;
    logic [DIV_Q_W-1:0]    den_reg;
    logic [DIV_Q_W-1:0]    rem_reg;
    logic [DIV_Q_W-1:0]    quot_reg;

    logic [DIV_Q_W:0]   shifted;
    logic [DIV_Q_W:0]   diff;
    logic               fits;
    logic [DIV_Q_W-1:0] rem_next;

    // one trial subtraction
    always_comb
    begin
        shifted  = {rem_reg, num_reg[DIV_NUM_W-1]};
        diff     = shifted - {1'b0, den_reg};
        fits     = (shifted >= {1'b0, den_reg});
        rem_next = fits ? diff[DIV_Q_W-1:0] : shifted[DIV_Q_W-1:0];
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg  <= req.num;
            den_reg  <= req.den;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg  <= {num_reg[DIV_NUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[DIV_Q_W-2:0], fits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
endmodule

// ===== sv/qmbl_sqrt.sv =====
// digit-by-digit integer square root, one root bit per cycle
module qmbl_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  qmbl_pkg::sqrt_req_t req,
    output qmbl_pkg::sqrt_rsp_t rsp
);
    import qmbl_pkg::*;

    localparam int REM_W = SQ_ROOT_W + 2;

    logic                 busy_reg;
    logic                 done_reg;
    logic [SQ_CNT_W-1:0]  cnt_reg;
    logic [SQ_RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [SQ_ROOT_W-1:0] root_reg;

    logic [REM_W+1:0] shifted;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             fits;

    // bring down two radicand bits and try the next root bit
    always_comb
    begin
        shifted = {rem_reg, rad_reg[SQ_RAD_W-1 -: 2]};
        trial   = {2'b00, root_reg, 2'b01};
        diff    = shifted - trial;
        fits    = (shifted >= trial);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SQ_CNT_W'(SQ_ROOT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == SQ_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= req.rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[SQ_RAD_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            root_reg <= {root_reg[SQ_ROOT_W-2:0], fits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.root = root_reg;
endmodule

// ===== sv/quadtree_map_bilinear_lookup.sv =====
// top level: node tables in rams, query sequencer, shared divider, root and multiplier
// a write beat is taken in the idle state; a query inside the box runs two 63-step divisions,
//   reads the root node and descends one layer at a time to a leaf or the depth limit, then interpolates
// a query outside the box runs 99- and 64-step divisions and a 32-step root; it saturates
//   without them at the origin, and without the root when the quotient saturates
// one beat is worked at a time; the 1-bit-per-cycle divider and result back-pressure set the rate
// reset clears control state and sets the box half width to 2.0; the tables hold
//   nothing defined until written, and there is no clearing pass
module quadtree_map_bilinear_lookup #(
    parameter int NODES  = qmbl_pkg::NODES_DEF,
    parameter int LAYERS = qmbl_pkg::LAYERS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [qmbl_pkg::BOX_W-1:0]   cfg_wr_data,
    qmbl_cmd_if.sink                     cmd,
    qmbl_res_if.source                   res
);
    import qmbl_pkg::*;

    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int NODE_DW   = CHILD_W + 1;
    localparam int CORNER_DW = 4 * MAG_W;

    // sequencer states
    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SQX      = 5'd1;
    localparam logic [4:0] S_SQY      = 5'd2;
    localparam logic [4:0] S_SUM      = 5'd3;
    localparam logic [4:0] S_PS_DIV1  = 5'd4;
    localparam logic [4:0] S_PS_WAIT1 = 5'd5;
    localparam logic [4:0] S_PS_DIV2  = 5'd6;
    localparam logic [4:0] S_PS_WAIT2 = 5'd7;
    localparam logic [4:0] S_PS_SQRT  = 5'd8;
    localparam logic [4:0] S_PS_WAIT3 = 5'd9;
    localparam logic [4:0] S_NRM_X    = 5'd10;
    localparam logic [4:0] S_WAIT_X   = 5'd11;
    localparam logic [4:0] S_NRM_Y    = 5'd12;
    localparam logic [4:0] S_WAIT_Y   = 5'd13;
    localparam logic [4:0] S_RED      = 5'd14;
    localparam logic [4:0] S_ROOT_RD  = 5'd15;
    localparam logic [4:0] S_ROOT_CHK = 5'd16;
    localparam logic [4:0] S_NODE_RD  = 5'd17;
    localparam logic [4:0] S_NODE_CHK = 5'd18;
    localparam logic [4:0] S_LEAF_RD  = 5'd19;
    localparam logic [4:0] S_LEAF_CAP = 5'd20;
    localparam logic [4:0] S_MUL0     = 5'd21;
    localparam logic [4:0] S_ACC0     = 5'd22;
    localparam logic [4:0] S_MUL1     = 5'd23;
    localparam logic [4:0] S_ACC1     = 5'd24;
    localparam logic [4:0] S_MUL2     = 5'd25;
    localparam logic [4:0] S_ACC2     = 5'd26;
    localparam logic [4:0] S_DONE     = 5'd27;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    logic [BOX_W-1:0] box_reg;

    // query work registers
    logic [POS_W-1:0]   x_reg;
    logic [POS_W-1:0]   y_reg;
    logic [63:0]        s_reg;
    logic [MAG_W-1:0]   fx_reg;
    logic [MAG_W-1:0]   fy_reg;
    logic [SUM_W-1:0]   idx_reg;
    logic [CHILD_W-1:0] seq_reg;
    logic [LW-1:0]      layer_reg;
    logic               limited_reg;
    logic               outside_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic [MAG_W-1:0]   ca_reg;
    logic [MAG_W-1:0]   cb_reg;
    logic [MAG_W-1:0]   cc_reg;
    logic [MAG_W-1:0]   cd_reg;
    logic [MAG_W-1:0]   lo_reg;
    logic [MAG_W-1:0]   hi_reg;
    logic signed [65:0] prod_reg;

    // output stage
    logic             res_valid_reg;
    logic [MAG_W-1:0] res_mag_reg;
    logic             res_out_reg;
    logic             res_dl_reg;

    logic [LS_W-1:0] ls_mem [LAYERS];

    logic cmd_acc;
    logic is_outside;
    logic res_load;

    logic                 node_we;
    logic [NODE_DW-1:0]   node_rdata;
    logic [CORNER_DW-1:0] corner_rdata;

    div_req_t  div_req;
    div_rsp_t  div_rsp;
    sqrt_req_t sqrt_req;
    sqrt_rsp_t sqrt_rsp;

    logic                  node_refined;
    logic [CHILD_W-1:0]    node_child;
    logic                  at_limit;
    logic [CHILD_W-1:0]    seq_new;
    logic [1:0]            quad;
    logic [LS_W-1:0]       ls_next;
    logic [SUM_W-1:0]      sum_next;
    logic [POS_W-1:0]      nx;
    logic [POS_W-1:0]      ny;
    logic signed [32:0]    mul_a;
    logic signed [32:0]    mul_b;
    logic [MAG_W-1:0]      acc_base;
    logic [33:0]           acc_sum;
    logic signed [32:0]    xs;
    logic signed [32:0]    ys;
    logic signed [32:0]    bs;

    assign cmd_acc   = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign res_load  = (state_reg == S_DONE) && (!res_valid_reg || res.ready);

    // box test on the incoming beat
    always_comb
    begin
        xs = {cmd.x_pos[POS_W-1], cmd.x_pos};
        ys = {cmd.y_pos[POS_W-1], cmd.y_pos};
        bs = $signed({2'b00, box_reg});
        is_outside = (xs <= -bs) || (xs >= bs) || (ys <= -bs) || (ys >= bs);
    end

    // node and corner tables
    assign node_we = cmd_acc && (cmd.command == CMD_NODE) && (int'(cmd.node_index) < NODES);

    qmbl_ram #(.WIDTH(NODE_DW), .DEPTH(NODES)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (NW'(cmd.node_index)),
        .wdata ({cmd.is_refined, cmd.child_block}),
        .raddr (NW'(idx_reg)),
        .rdata (node_rdata)
    );

    qmbl_ram #(.WIDTH(CORNER_DW), .DEPTH(NODES)) u_corner_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (NW'(cmd.node_index)),
        .wdata ({cmd.corner_d, cmd.corner_c, cmd.corner_b, cmd.corner_a}),
        .raddr (NW'(idx_reg)),
        .rdata (corner_rdata)
    );

    // layer start table
    always_ff @(posedge clk)
    begin
        if (cmd_acc && (cmd.command == CMD_LAYER) && (int'(cmd.layer_number) < LAYERS))
        begin
            ls_mem[LW'(cmd.layer_number)] <= cmd.layer_start;
        end
    end

    // descent step
    always_comb
    begin
        node_refined = node_rdata[CHILD_W];
        node_child   = node_rdata[CHILD_W-1:0];
        at_limit     = (int'(layer_reg) + 1 >= LAYERS);
        seq_new      = (layer_reg != '0) ? node_child : seq_reg;
        quad         = {fy_reg[MAG_W-1], fx_reg[MAG_W-1]};
        ls_next      = ls_mem[LW'(layer_reg + 1'b1)];
        sum_next     = SUM_W'(ls_next) + {1'b0, seq_new, 2'b00} + SUM_W'(quad);
    end

    // shared divider and root requests
    always_comb
    begin
        nx = x_reg + {1'b0, box_reg};
        ny = y_reg + {1'b0, box_reg};
        div_req = '0;
        case (state_reg)
            S_PS_DIV1:
            begin
                div_req.start = (s_reg != '0);
                div_req.num   = {1'b1, {(DIV_NUM_W-1){1'b0}}};
                div_req.den   = s_reg + 64'h4_0000_0000;
                div_req.steps = DIV_STEP_W'(99);
            end
            S_PS_DIV2:
            begin
                div_req.start = 1'b1;
                div_req.num   = {div_rsp.quot, 35'b0};
                div_req.den   = s_reg;
                div_req.steps = DIV_STEP_W'(64);
            end
            S_NRM_X:
            begin
                div_req.start = 1'b1;
                div_req.num   = {nx, 67'b0};
                div_req.den   = {33'b0, box_reg};
                div_req.steps = DIV_STEP_W'(63);
            end
            S_NRM_Y:
            begin
                div_req.start = 1'b1;
                div_req.num   = {ny, 67'b0};
                div_req.den   = {33'b0, box_reg};
                div_req.steps = DIV_STEP_W'(63);
            end
            default:
            begin
                div_req = '0;
            end
        endcase
        sqrt_req.start = (state_reg == S_PS_SQRT);
        sqrt_req.rad   = 64'h1_0000_0000 + div_rsp.quot;
    end

    qmbl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    qmbl_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rsp   (sqrt_rsp)
    );

    // shared multiplier operands
    always_comb
    begin
        case (state_reg)
            S_SQX:
            begin
                mul_a = $signed({x_reg[POS_W-1], x_reg});
                mul_b = $signed({x_reg[POS_W-1], x_reg});
            end
            S_SQY:
            begin
                mul_a = $signed({y_reg[POS_W-1], y_reg});
                mul_b = $signed({y_reg[POS_W-1], y_reg});
            end
            S_MUL0:
            begin
                mul_a = $signed({1'b0, cb_reg} - {1'b0, ca_reg});
                mul_b = $signed({1'b0, fx_reg});
            end
            S_MUL1:
            begin
                mul_a = $signed({1'b0, cd_reg} - {1'b0, cc_reg});
                mul_b = $signed({1'b0, fx_reg});
            end
            S_MUL2:
            begin
                mul_a = $signed({1'b0, hi_reg} - {1'b0, lo_reg});
                mul_b = $signed({1'b0, fy_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // lerp accumulate: base + floor(diff * f / 2^32)
    always_comb
    begin
        case (state_reg)
            S_ACC0:  acc_base = ca_reg;
            S_ACC1:  acc_base = cc_reg;
            default: acc_base = lo_reg;
        endcase
        acc_sum = {2'b00, acc_base} + prod_reg[65:32];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc && (cmd.command == CMD_QUERY))
                begin
                    state_next = is_outside ? S_SQX : S_NRM_X;
                end
            end
            S_SQX:      state_next = S_SQY;
            S_SQY:      state_next = S_SUM;
            S_SUM:      state_next = S_PS_DIV1;
            S_PS_DIV1:  state_next = (s_reg == '0) ? S_DONE : S_PS_WAIT1;
            S_PS_WAIT1: state_next = div_rsp.done ? S_PS_DIV2 : S_PS_WAIT1;
            S_PS_DIV2:  state_next = S_PS_WAIT2;
            S_PS_WAIT2:
            begin
                if (div_rsp.done)
                begin
                    state_next = (&div_rsp.quot[63:32]) ? S_DONE : S_PS_SQRT;
                end
            end
            S_PS_SQRT:  state_next = S_PS_WAIT3;
            S_PS_WAIT3: state_next = sqrt_rsp.done ? S_DONE : S_PS_WAIT3;
            S_NRM_X:    state_next = S_WAIT_X;
            S_WAIT_X:   state_next = div_rsp.done ? S_NRM_Y : S_WAIT_X;
            S_NRM_Y:    state_next = S_WAIT_Y;
            S_WAIT_Y:   state_next = div_rsp.done ? S_RED : S_WAIT_Y;
            S_RED:
            begin
                if (int'(idx_reg) < NODES)
                begin
                    state_next = (layer_reg == '0) ? S_ROOT_RD : S_NODE_RD;
                end
            end
            S_ROOT_RD:  state_next = S_ROOT_CHK;
            S_ROOT_CHK: state_next = S_NODE_RD;
            S_NODE_RD:  state_next = S_NODE_CHK;
            S_NODE_CHK: state_next = (!node_refined || at_limit) ? S_LEAF_RD : S_RED;
            S_LEAF_RD:  state_next = S_LEAF_CAP;
            S_LEAF_CAP: state_next = S_MUL0;
            S_MUL0:     state_next = S_ACC0;
            S_ACC0:     state_next = S_MUL1;
            S_MUL1:     state_next = S_ACC1;
            S_ACC1:     state_next = S_MUL2;
            S_MUL2:     state_next = S_ACC2;
            S_ACC2:     state_next = S_DONE;
            S_DONE:     state_next = res_load ? S_IDLE : S_DONE;
            default:    state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            box_reg       <= BOX_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                box_reg <= cfg_wr_data;
            end
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // query datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_acc)
                begin
                    x_reg       <= cmd.x_pos;
                    y_reg       <= cmd.y_pos;
                    outside_reg <= is_outside;
                    limited_reg <= 1'b0;
                end
            end
            S_SQY:
            begin
                s_reg <= prod_reg[63:0];
            end
            S_SUM:
            begin
                s_reg <= s_reg + prod_reg[63:0];
            end
            S_PS_DIV1:
            begin
                mag_reg <= MAG_SAT;
            end
            S_PS_WAIT2:
            begin
                mag_reg <= MAG_SAT;
            end
            S_PS_WAIT3:
            begin
                mag_reg <= sqrt_rsp.root;
            end
            S_WAIT_X:
            begin
                fx_reg <= div_rsp.quot[MAG_W-1:0];
            end
            S_WAIT_Y:
            begin
                fy_reg    <= div_rsp.quot[MAG_W-1:0];
                idx_reg   <= SUM_W'(ls_mem[0]);
                layer_reg <= '0;
            end
            S_RED:
            begin
                if (int'(idx_reg) >= NODES)
                begin
                    idx_reg <= idx_reg - SUM_W'(NODES);
                end
            end
            S_ROOT_CHK:
            begin
                seq_reg <= node_child;
                idx_reg <= '0;
            end
            S_NODE_CHK:
            begin
                if (node_refined)
                begin
                    if (at_limit)
                    begin
                        limited_reg <= 1'b1;
                    end
                    else
                    begin
                        seq_reg   <= seq_new;
                        fx_reg    <= {fx_reg[MAG_W-2:0], 1'b0};
                        fy_reg    <= {fy_reg[MAG_W-2:0], 1'b0};
                        layer_reg <= layer_reg + 1'b1;
                        idx_reg   <= sum_next;
                    end
                end
            end
            S_LEAF_CAP:
            begin
                ca_reg <= corner_rdata[MAG_W-1:0];
                cb_reg <= corner_rdata[2*MAG_W-1:MAG_W];
                cc_reg <= corner_rdata[3*MAG_W-1:2*MAG_W];
                cd_reg <= corner_rdata[4*MAG_W-1:3*MAG_W];
            end
            S_ACC0:
            begin
                lo_reg <= acc_sum[MAG_W-1:0];
            end
            S_ACC1:
            begin
                hi_reg <= acc_sum[MAG_W-1:0];
            end
            S_ACC2:
            begin
                mag_reg <= acc_sum[MAG_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // result beat register
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_mag_reg <= mag_reg;
            res_out_reg <= outside_reg;
            res_dl_reg  <= limited_reg && !outside_reg;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.magnification = res_mag_reg;
    assign res.outside_box   = res_out_reg;
    assign res.depth_limited = res_dl_reg;

    // checks
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.outside_box && res.depth_limited))
        else $error("result flags both set");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NODE_RD || state_reg == S_LEAF_RD) |-> (int'(idx_reg) < NODES))
        else $error("node index not reduced");

    a_layer_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NODE_CHK) |-> (int'(layer_reg) < LAYERS))
        else $error("layer beyond limit");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for the quadtree magnification map lookup
`timescale 1ns / 1ps

module tb_top;
    import qmbl_pkg::*;

    localparam int NNODES   = NODES_DEF;
    localparam int NLAYERS  = LAYERS_DEF;
    localparam int IDLE_MAX = 4000;

    // the map is kept small: layer starts and child blocks are bounded so that
    // every node a descent can reach lies below MAP_N, or is the top node
    localparam int MAP_N       = 64;
    localparam int MAP_LS_MAX  = 31;
    localparam int MAP_KID_MAX = 7;

    // command code with no function
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]        command;
        logic [NIDX_W-1:0]       node_index;
        logic [LNUM_W-1:0]       layer_number;
        logic [LS_W-1:0]         layer_start;
        logic                    is_refined;
        logic [CHILD_W-1:0]      child_block;
        logic [MAG_W-1:0]        ca, cb, cc, cd;
        logic signed [POS_W-1:0] x, y;
    } beat_t;

    typedef struct {
        logic [MAG_W-1:0] mag;
        logic             outside;
        logic             limited;
    } mag_t;

    typedef struct {
        beat_t b;
        bit    typed;
        mag_t  e;
    } row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en = 1'b0;
    logic [BOX_W-1:0] cfg_wr_data = '0;

    qmbl_cmd_if cmd();
    qmbl_res_if res();

    quadtree_map_bilinear_lookup dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd.sink),
        .res         (res.source)
    );

    // shadow copy of the map tables and the box register
    bit               map_refined [NNODES];
    bit [CHILD_W-1:0] map_child   [NNODES];
    bit [MAG_W-1:0]   map_corner  [4*NNODES];
    bit [LS_W-1:0]    map_lstart  [NLAYERS];
    bit [BOX_W-1:0]   map_box = BOX_RESET;

    mag_t pending_mags[$];
    row_t lookup_rows[$];
    int   errors = 0;
    bit   quiet = 1'b0;
    int   refine_pct = 50;
    int   idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic logic [MAG_W-1:0] blend(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] f);
        logic [65:0] acc;
        acc = 66'(a) * (66'h1_0000_0000 - 66'(f)) + 66'(b) * 66'(f);
        return acc[63:32];
    endfunction

    // (u+2)/sqrt(u(u+4)) in q16.16 through 4/(u(u+4)) and an integer root
    function automatic logic [MAG_W-1:0] point_source_mag(input longint x, input longint y);
        logic [63:0] s, t, n, root, bt;
        logic [98:0] q;
        s = 64'(x * x) + 64'(y * y);
        if (s == 0)
            return MAG_SAT;
        q = (99'b1 << 98) / (99'(s) + (99'b1 << 34));
        q = q / 99'(s);
        t = q[63:0];
        if (t > 64'hFFFF_FFFF_FFFF_FFFF - 64'h1_0000_0000)
            return MAG_SAT;
        n = 64'h1_0000_0000 + t;
        root = 0;
        bt = 64'd1 << 62;
        while (bt > n)
            bt = bt >> 2;
        while (bt != 0)
        begin
            if (n >= root + bt)
            begin
                n = n - (root + bt);
                root = (root >> 1) + bt;
            end
            else
                root = root >> 1;
            bt = bt >> 2;
        end
        return root[31:0];
    endfunction

    // updates the shadow tables; returns 1 when the beat yields a magnification
    function automatic bit lookup_magnification(input beat_t b, output mag_t m);
        longint x, y, bw;
        logic [63:0] num;
        logic [31:0] fx, fy, lo, hi;
        int idx, seq, layer, q;
        m = '{default: '0};
        case (b.command)
            CMD_NODE:
            begin
                map_refined[b.node_index] = b.is_refined;
                map_child[b.node_index] = b.child_block;
                map_corner[4*b.node_index]   = b.ca;
                map_corner[4*b.node_index+1] = b.cb;
                map_corner[4*b.node_index+2] = b.cc;
                map_corner[4*b.node_index+3] = b.cd;
                return 0;
            end
            CMD_LAYER:
            begin
                map_lstart[b.layer_number] = b.layer_start;
                return 0;
            end
            CMD_QUERY: ;
            default: return 0;
        endcase
        x = b.x;
        y = b.y;
        bw = longint'(map_box);
        if (x <= -bw || x >= bw || y <= -bw || y >= bw)
        begin
            m.mag = point_source_mag(x, y);
            m.outside = 1'b1;
            return 1;
        end
        num = 64'(x + bw) << 31;
        fx = 32'(num / 64'(bw));
        num = 64'(y + bw) << 31;
        fy = 32'(num / 64'(bw));
        // descend through refined nodes
        idx = 0;
        layer = 0;
        seq = map_child[map_lstart[0] % NNODES];
        while (map_refined[idx])
        begin
            if (layer + 1 >= NLAYERS)
            begin
                m.limited = 1'b1;
                break;
            end
            if (layer != 0)
                seq = map_child[idx];
            q = {30'b0, fy[31], fx[31]};
            fx = fx << 1;
            fy = fy << 1;
            layer++;
            idx = (map_lstart[layer] + 4 * seq + q) % NNODES;
        end
        lo = blend(map_corner[4*idx], map_corner[4*idx+1], fx);
        hi = blend(map_corner[4*idx+2], map_corner[4*idx+3], fx);
        m.mag = blend(lo, hi, fy);
        return 1;
    endfunction

    // drive one beat, hold it until taken, then predict
    task automatic send_beat(input beat_t b, input bit typed, input mag_t e);
        mag_t m;
        if (!quiet && $urandom_range(0, 99) < 20)
        begin
            cmd.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cmd.valid <= 1'b1;
        cmd.command <= b.command;
        cmd.node_index <= b.node_index;
        cmd.layer_number <= b.layer_number;
        cmd.layer_start <= b.layer_start;
        cmd.is_refined <= b.is_refined;
        cmd.child_block <= b.child_block;
        cmd.corner_a <= b.ca;
        cmd.corner_b <= b.cb;
        cmd.corner_c <= b.cc;
        cmd.corner_d <= b.cd;
        cmd.x_pos <= b.x;
        cmd.y_pos <= b.y;
        do @(posedge clk); while (!cmd.ready);
        if (lookup_magnification(b, m))
        begin
            if (typed && (m.mag !== e.mag || m.outside !== e.outside
                          || m.limited !== e.limited))
                report($sformatf("typed value %h disagrees with prediction %h", e.mag, m.mag));
            pending_mags.push_back(m);
        end
    endtask

    function automatic beat_t node_beat(input int n, input bit refd, input int kid,
                                        input logic [31:0] a, b, c, d);
        beat_t r;
        r = '{default: '0};
        r.command = CMD_NODE;
        r.node_index = NIDX_W'(n);
        r.is_refined = refd;
        r.child_block = CHILD_W'(kid);
        r.ca = a; r.cb = b; r.cc = c; r.cd = d;
        return r;
    endfunction

    function automatic beat_t query_beat(input logic [31:0] x, input logic [31:0] y);
        beat_t r;
        r = '{default: '0};
        r.command = CMD_QUERY;
        r.x = x;
        r.y = y;
        return r;
    endfunction

    function automatic beat_t random_node(input int n);
        return node_beat(n, $urandom_range(0, 99) < refine_pct, $urandom_range(0, MAP_KID_MAX),
                         $urandom, $urandom, $urandom, $urandom);
    endfunction

    function automatic beat_t random_query();
        longint bw, xv, yv;
        int r;
        bw = longint'(map_box);
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            xv = longint'({$urandom, $urandom} % (2 * bw - 1)) - (bw - 1);
            yv = longint'({$urandom, $urandom} % (2 * bw - 1)) - (bw - 1);
        end
        else if (r < 9)
        begin
            xv = $signed($urandom);
            yv = $signed($urandom);
        end
        else
        begin
            xv = bw * ($urandom_range(0, 1) ? 1 : -1);
            yv = $urandom_range(0, 1) ? -64'sd2147483648 : 64'sd2147483647;
        end
        return query_beat(32'(xv), 32'(yv));
    endfunction

    // load the layer starts and every node that a descent can reach
    task automatic load_map();
        mag_t none;
        beat_t b;
        none = '{default: '0};
        for (int l = 0; l < NLAYERS; l++)
        begin
            b = '{default: '0};
            b.command = CMD_LAYER;
            b.layer_number = LNUM_W'(l);
            b.layer_start = LS_W'($urandom_range(0, MAP_LS_MAX));
            send_beat(b, 0, none);
        end
        for (int n = 0; n < MAP_N; n++)
            send_beat(random_node(n), 0, none);
        send_beat(random_node(NNODES - 1), 0, none);
    endtask

    task automatic drain();
        cmd.valid <= 1'b0;
        while (pending_mags.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_box(input logic [BOX_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        map_box = v;
    endtask

    // result receiver with random stalls
    always @(posedge clk)
    begin
        res.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 20);
    end

    // result checker
    always @(posedge clk)
    begin
        mag_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_mags.size() == 0)
                report("result beat with no query outstanding");
            else
            begin
                want = pending_mags.pop_front();
                if (res.magnification !== want.mag)
                    report($sformatf("magnification %h, want %h", res.magnification, want.mag));
                if (res.outside_box !== want.outside)
                    report($sformatf("outside_box %b, want %b", res.outside_box, want.outside));
                if (res.depth_limited !== want.limited)
                    report($sformatf("depth_limited %b, want %b", res.depth_limited,
                                     want.limited));
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (res.valid && res.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_MAX)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        mag_t none;
        beat_t b;
        logic [BOX_W-1:0] boxes[5];
        int pcts[5];
        none = '{default: '0};
        boxes = '{31'h7FFF_FFFF, 31'd1, 31'h0001_0000, 31'h0, 31'h0000_8000};
        boxes[3] = BOX_W'($urandom_range(1, 32'h7FFF_FFFF));
        pcts = '{85, 100, 97, 30, 60};
        rst_n = 1'b0;
        cmd.valid = 1'b0;
        cmd.command = CMD_NODE;
        cmd.node_index = '0;
        cmd.layer_number = '0;
        cmd.layer_start = '0;
        cmd.is_refined = 1'b0;
        cmd.child_block = '0;
        cmd.corner_a = '0;
        cmd.corner_b = '0;
        cmd.corner_c = '0;
        cmd.corner_d = '0;
        cmd.x_pos = '0;
        cmd.y_pos = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        load_map();

        // directed rows at the reset box half width of 2.0
        lookup_rows.push_back('{node_beat(0, 0, 0, 32'h12345678, 32'h12345678,
                                32'h12345678, 32'h12345678), 0, none});
        lookup_rows.push_back('{query_beat(0, 0), 1, '{32'h12345678, 0, 0}});
        lookup_rows.push_back('{query_beat(32'h7FFF_FFFF, 32'h7FFF_FFFF), 0, none});
        lookup_rows.push_back('{query_beat(32'h8000_0000, 32'h8000_0000), 0, none});
        lookup_rows.push_back('{query_beat(32'h0001_FFFF, 32'hFFFE_0001), 0, none});
        lookup_rows.push_back('{query_beat(32'h0002_0000, 0), 0, none});
        lookup_rows.push_back('{query_beat(0, 32'hFFFE_0000), 0, none});
        lookup_rows.push_back('{node_beat(0, 0, 0, '1, '1, '1, '1), 0, none});
        lookup_rows.push_back('{query_beat(5, -7), 1, '{MAG_SAT, 0, 0}});
        lookup_rows.push_back('{node_beat(0, 0, 1023, 0, 0, 0, 0), 0, none});
        lookup_rows.push_back('{query_beat(32'h0001_0000, 32'hFFFF_0000), 1, '{0, 0, 0}});
        lookup_rows.push_back('{node_beat(0, 0, 0, 0, '1, 0, '1), 0, none});
        lookup_rows.push_back('{query_beat(32'h0000_8000, 32'h0000_4000), 0, none});
        b = '{default: '0};
        b.command = CMD_SPARE;
        b.x = 0;
        lookup_rows.push_back('{b, 0, none});
        b = '{default: '0};
        b.command = CMD_LAYER;
        b.layer_number = 4'd15;
        b.layer_start = 12'hFFF;
        lookup_rows.push_back('{b, 0, none});
        lookup_rows.push_back('{node_beat(0, 1, MAP_KID_MAX, '1, '1, '1, '1), 0, none});
        lookup_rows.push_back('{query_beat(32'h0001_8000, 32'hFFFE_8000), 0, none});
        lookup_rows.push_back('{query_beat(32'hFFFF_FFFF, 32'h0000_0001), 0, none});
        foreach (lookup_rows[i])
            send_beat(lookup_rows[i].b, lookup_rows[i].typed, lookup_rows[i].e);
        drain();

        // random phases over box widths and refinement densities
        for (int ph = 0; ph < 5; ph++)
        begin
            write_box(boxes[ph]);
            refine_pct = pcts[ph];
            quiet = (ph == 2);
            if (ph == 1 || ph == 3)
                load_map();
            for (int k = 0; k < 55; k++)
            begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 25)
                    b = random_node($urandom_range(0, MAP_N - 1));
                else if (r < 30)
                begin
                    b = '{default: '0};
                    b.command = CMD_LAYER;
                    b.layer_number = LNUM_W'($urandom_range(0, 15));
                    b.layer_start = LS_W'($urandom_range(0, MAP_LS_MAX));
                end
                else if (r < 33)
                begin
                    b = random_query();
                    b.command = CMD_SPARE;
                end
                else
                    b = random_query();
                send_beat(b, 0, none);
            end
            drain();
        end
        write_box(BOX_RESET);
        quiet = 1'b0;
        for (int k = 0; k < 20; k++)
            send_beat(random_query(), 0, none);
        drain();

        if (pending_mags.size() != 0)
            report("queries left without a result");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
